### rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the difficulty retarget pipeline.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int WIDE       = 256;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = WIDE / DIV_STEP;

  localparam logic [1:0] CFG_TIMESPAN = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_NORET    = 2'd2;

  localparam logic [31:0] TIMESPAN_RST = 32'd1209600;
  localparam logic [31:0] LIMIT_RST    = 32'h1d00ffff;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  typedef struct packed {
    logic [31:0] last_bits;
    logic [1:0]  clamp;
    logic        noret;
    logic        tiny;
  } side_t;

endpackage

### rtl/difficulty_retarget_top.sv
// Each item is registered through the front, divider and back stages in order.
// Throughput: one item per cycle when not stalled; the 256-bit divider retires
// 4 quotient bits per stage, so its 64 stages set the latency.
// A full output register with out_ready_i low stalls the whole pipeline.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// difficulty_retarget_top
// Compact target retarget pipeline with configuration registers.
// ----------------------------------------------------------------------------
module difficulty_retarget_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] last_bits_i,
  input  logic [31:0] last_time_i,
  input  logic [31:0] first_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_bits_o,
  output logic [1:0]  span_clamp_o,
  output logic        capped_o
);
  import drt_pkg::*;

  logic [31:0]  timespan_q, limit_q;
  logic         noret_q;
  logic         en;
  logic         fv, dv;
  logic [255:0] dividend, quot;
  side_t        fside, dside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timespan_q <= TIMESPAN_RST;
      limit_q    <= LIMIT_RST;
      noret_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMESPAN: timespan_q <= cfg_data_i;
        CFG_LIMIT:    limit_q    <= cfg_data_i;
        CFG_NORET:    noret_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  drt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .last_bits_i  (last_bits_i),
    .last_time_i  (last_time_i),
    .first_time_i (first_time_i),
    .timespan_i   (timespan_q),
    .noret_i      (noret_q),
    .valid_o      (fv),
    .dividend_o   (dividend),
    .side_o       (fside)
  );

  drt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (fv),
    .dividend_i (dividend),
    .side_i     (fside),
    .timespan_i (timespan_q),
    .valid_o    (dv),
    .quot_o     (quot),
    .side_o     (dside)
  );

  drt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (dv),
    .quot_i       (quot),
    .side_i       (dside),
    .timespan_i   (timespan_q),
    .limit_i      (limit_q),
    .valid_o      (out_valid_o),
    .new_bits_o   (new_bits_o),
    .span_clamp_o (span_clamp_o),
    .capped_o     (capped_o)
  );

  a_capped_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capped_o |-> !new_bits_o[23])
    else $error("capped result has sign bit set");

  a_clamp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_clamp_o != 2'd3)
    else $error("invalid clamp code");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("stall without a waiting result");

endmodule

### rtl/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front
// Span clamp, compact decode, span multiply and dividend alignment (4 stages).
// ----------------------------------------------------------------------------
module drt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [31:0]              last_bits_i,
  input  logic [31:0]              last_time_i,
  input  logic [31:0]              first_time_i,
  input  logic [31:0]              timespan_i,
  input  logic                     noret_i,
  output logic                     valid_o,
  output logic [255:0]             dividend_o,
  output drt_pkg::side_t           side_o
);
  import drt_pkg::*;

  logic signed [35:0] sp36, lo36, hi36, spc36;
  logic [1:0]         clamp;
  logic [7:0]         size;
  logic [22:0]        m_eff;
  logic               low_exp;

  logic               v1_q, v2_q, v3_q, v4_q;
  side_t              s1_q, s2_q, s3_q, s4_q, s1_d, s2_d;
  logic [33:0]        span1_q;
  logic [22:0]        m1_q;
  logic [7:0]         sh1_q, sh2_q, sh3_q;
  logic               low_exp1_q;
  logic [56:0]        prod2_q;
  logic [58:0]        x3_q, x3_d;
  logic               tiny2;
  logic [255:0]       div4_q, div4_d;

  always_comb begin
    sp36  = $signed({4'b0, last_time_i}) - $signed({4'b0, first_time_i});
    lo36  = $signed({6'b0, timespan_i[31:2]});
    hi36  = $signed({2'b0, timespan_i, 2'b0});
    spc36 = sp36;
    clamp = CLAMP_NONE;
    if (sp36 < lo36) begin
      spc36 = lo36;
      clamp = CLAMP_LOW;
    end
    if (spc36 > hi36) begin
      spc36 = hi36;
      clamp = CLAMP_HIGH;
    end
    size    = last_bits_i[31:24];
    low_exp = (size <= 8'd3);
    case (size)
      8'd0:    m_eff = 23'd0;
      8'd1:    m_eff = {16'd0, last_bits_i[22:16]};
      8'd2:    m_eff = {8'd0, last_bits_i[22:8]};
      default: m_eff = last_bits_i[22:0];
    endcase
    s1_d.last_bits = last_bits_i;
    s1_d.clamp     = clamp;
    s1_d.noret     = noret_i;
    s1_d.tiny      = 1'b0;
  end

  always_comb begin
    if (low_exp1_q) begin
      tiny2 = (m1_q <= 23'd3);
    end else if (sh1_q >= 8'd32) begin
      tiny2 = 1'b1;
    end else if (sh1_q == 8'd31) begin
      tiny2 = (m1_q[7:0] == 8'd0);
    end else if (sh1_q == 8'd30) begin
      tiny2 = (m1_q[15:0] == 16'd0);
    end else begin
      tiny2 = (m1_q == 23'd0);
    end
    s2_d      = s1_q;
    s2_d.tiny = tiny2;
  end

  always_comb begin
    if (s2_q.tiny) begin
      x3_d = {2'b0, prod2_q} + {1'b0, prod2_q, 1'b0};
    end else begin
      x3_d = {2'b0, prod2_q};
    end
    if (sh3_q[7:5] != 3'd0) begin
      div4_d = '0;
    end else begin
      div4_d = {197'd0, x3_q} << {sh3_q[4:0], 3'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q       <= s1_d;
      span1_q    <= spc36[33:0];
      m1_q       <= m_eff;
      low_exp1_q <= low_exp;
      sh1_q      <= low_exp ? 8'd0 : size - 8'd3;
      s2_q       <= s2_d;
      prod2_q    <= {34'd0, m1_q} * {23'd0, span1_q};
      sh2_q      <= sh1_q;
      s3_q       <= s2_q;
      x3_q       <= x3_d;
      sh3_q      <= sh2_q;
      s4_q       <= s3_q;
      div4_q     <= div4_d;
    end
  end

  assign valid_o    = v4_q;
  assign dividend_o = div4_q;
  assign side_o     = s4_q;

endmodule

### rtl/drt_div.sv
// ----------------------------------------------------------------------------
// drt_div
// Pipelined restoring divider, 256 by 32 bits, four quotient bits per stage.
// ----------------------------------------------------------------------------
module drt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [255:0]      dividend_i,
  input  drt_pkg::side_t    side_i,
  input  logic [31:0]       timespan_i,
  output logic              valid_o,
  output logic [255:0]      quot_o,
  output drt_pkg::side_t    side_o
);
  import drt_pkg::*;

  logic         vld_q  [DIV_STAGES];
  logic [255:0] num_q  [DIV_STAGES];
  logic [31:0]  rem_q  [DIV_STAGES];
  side_t        side_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic         vld_in;
    logic [255:0] num_in, num_d;
    logic [31:0]  rem_in, rem_d;
    side_t        side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign num_in  = dividend_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [32:0] t;
      num_d = num_in;
      rem_d = rem_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        t     = {rem_d, num_d[255]};
        num_d = {num_d[254:0], 1'b0};
        if (t >= {1'b0, timespan_i}) begin
          t        = t - {1'b0, timespan_i};
          num_d[0] = 1'b1;
        end
        rem_d = t[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= num_d;
        rem_q[k]  <= rem_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = num_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

### rtl/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back
// Tiny-target raise, limit cap and compact encode (4 stages, last is output).
// ----------------------------------------------------------------------------
module drt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [255:0]      quot_i,
  input  drt_pkg::side_t    side_i,
  input  logic [31:0]       timespan_i,
  input  logic [31:0]       limit_i,
  output logic              valid_o,
  output logic [31:0]       new_bits_o,
  output logic [1:0]        span_clamp_o,
  output logic              capped_o
);
  import drt_pkg::*;

  function automatic logic [255:0] decode(input logic [31:0] b);
    logic [7:0]   sz;
    logic [255:0] r;
    sz = b[31:24];
    case (sz)
      8'd0:    r = '0;
      8'd1:    r = {249'd0, b[22:16]};
      8'd2:    r = {241'd0, b[22:8]};
      8'd3:    r = {233'd0, b[22:0]};
      default: begin
        if (sz - 8'd3 >= 8'd32) begin
          r = '0;
        end else begin
          r = {233'd0, b[22:0]} << {5'(sz - 8'd3), 3'b0};
        end
      end
    endcase
    return r;
  endfunction

  logic [255:0] lim_q;
  logic         va_q, vb_q, vc_q, vd_q;
  side_t        sa_q, sb_q, sc_q;
  logic [255:0] qa_q, qa_d, vb_q_val, vc_val_q;
  logic         cb_q, cc_q;
  logic [7:0]   nz_c_q;
  logic [1:0]   hb_c_q [8];
  logic [7:0]   nz_d;
  logic [1:0]   hb_d [8];
  logic [5:0]   size;
  logic [271:0] vpad;
  logic [23:0]  cval;
  logic [7:0]   size8;
  logic [31:0]  bits_d;
  logic [31:0]  bits_q;
  logic [1:0]   clamp_q;
  logic         capped_q;

  always_comb begin
    if (timespan_i == 32'd0) begin
      qa_d = '1;
    end else begin
      qa_d = quot_i;
    end
    if (side_i.tiny) begin
      qa_d = qa_d + 256'd3;
    end
  end

  always_comb begin
    for (int w = 0; w < 8; w++) begin
      nz_d[w] = (vb_q_val[32*w +: 32] != 32'd0);
      if (vb_q_val[32*w+24 +: 8] != 8'd0) begin
        hb_d[w] = 2'd3;
      end else if (vb_q_val[32*w+16 +: 8] != 8'd0) begin
        hb_d[w] = 2'd2;
      end else if (vb_q_val[32*w+8 +: 8] != 8'd0) begin
        hb_d[w] = 2'd1;
      end else begin
        hb_d[w] = 2'd0;
      end
    end
  end

  always_comb begin
    size = '0;
    for (int w = 0; w < 8; w++) begin
      if (nz_c_q[w]) begin
        size = {3'(w), hb_c_q[w]} + 6'd1;
      end
    end
    vpad = {vc_val_q, 16'd0};
    if (size == 6'd0) begin
      cval = '0;
    end else begin
      cval = vpad[{size - 6'd1, 3'b0} +: 24];
    end
    size8 = {2'b0, size};
    if (cval[23]) begin
      cval  = {8'd0, cval[23:8]};
      size8 = size8 + 8'd1;
    end
    if (sc_q.noret) begin
      bits_d = sc_q.last_bits;
    end else begin
      bits_d = {size8, cval};
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= decode(limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q     <= side_i;
      qa_q     <= qa_d;
      sb_q     <= sa_q;
      cb_q     <= (qa_q > lim_q);
      vb_q_val <= (qa_q > lim_q) ? lim_q : qa_q;
      sc_q     <= sb_q;
      cc_q     <= cb_q;
      vc_val_q <= vb_q_val;
      nz_c_q   <= nz_d;
      hb_c_q   <= hb_d;
      bits_q   <= bits_d;
      clamp_q  <= sc_q.noret ? CLAMP_NONE : sc_q.clamp;
      capped_q <= cc_q & ~sc_q.noret;
    end
  end

  assign valid_o      = vd_q;
  assign new_bits_o   = bits_q;
  assign span_clamp_o = clamp_q;
  assign capped_o     = capped_q;

endmodule
